/* design/xuv_pkg.sv */
// Shared types, codes and helper functions for the unwind descriptor validator.
package xuv_pkg;

    // Verdict codes
    localparam logic [3:0] ERR_OK          = 4'd0;
    localparam logic [3:0] ERR_HEADER      = 4'd1;
    localparam logic [3:0] ERR_TRUNCATED   = 4'd2;
    localparam logic [3:0] ERR_ORDER       = 4'd3;
    localparam logic [3:0] ERR_PUSH_VOL    = 4'd4;
    localparam logic [3:0] ERR_ALLOC       = 4'd5;
    localparam logic [3:0] ERR_FPREG       = 4'd6;
    localparam logic [3:0] ERR_SAVE_VOL    = 4'd7;
    localparam logic [3:0] ERR_XMM         = 4'd8;
    localparam logic [3:0] ERR_MACHFRAME   = 4'd9;
    localparam logic [3:0] ERR_OPCODE      = 4'd10;
    localparam logic [3:0] ERR_MULTISLOT   = 4'd11;
    localparam logic [3:0] ERR_PAD         = 4'd12;
    localparam logic [3:0] ERR_INCONSIST   = 4'd13;
    localparam logic [3:0] ERR_BAD_FRAME   = 4'd14;
    localparam logic [3:0] ERR_TRAILING    = 4'd15;

    // Unwind operation codes
    localparam logic [3:0] UOP_PUSH_NONVOL     = 4'd0;
    localparam logic [3:0] UOP_ALLOC_LARGE     = 4'd1;
    localparam logic [3:0] UOP_ALLOC_SMALL     = 4'd2;
    localparam logic [3:0] UOP_SET_FPREG       = 4'd3;
    localparam logic [3:0] UOP_SAVE_NONVOL     = 4'd4;
    localparam logic [3:0] UOP_SAVE_NONVOL_FAR = 4'd5;
    localparam logic [3:0] UOP_SAVE_XMM128     = 4'd8;
    localparam logic [3:0] UOP_SAVE_XMM128_FAR = 4'd9;
    localparam logic [3:0] UOP_PUSH_MACHFRAME  = 4'd10;

    // Header layout and counter limits
    localparam logic [9:0] IDX_VERSION  = 10'd0;
    localparam logic [9:0] IDX_PROLOGUE = 10'd1;
    localparam logic [9:0] IDX_SLOTS    = 10'd2;
    localparam logic [9:0] IDX_FRAME    = 10'd3;
    localparam logic [9:0] HDR_BYTES    = 10'd4;
    localparam logic [9:0] IDX_SAT      = 10'd517;
    localparam logic [7:0] HDR_VERSION_FLAGS = 8'd1;
    localparam logic [8:0] LAST_OFS_RESET    = 9'd256;
    localparam logic [1:0] FP_SAT            = 2'd2;

    // Result of evaluating one head slot
    typedef struct packed {
        logic [3:0] err;
        logic       off_ok;
        logic       fp_inc;
        logic [8:0] next_slot;
    } head_res_t;

    // Nonvolatile general purpose register
    function automatic logic gpr_kept(input logic [3:0] r);
        gpr_kept = (r == 4'd3) || (r == 4'd5) || (r == 4'd6) || (r == 4'd7) ||
                   (r >= 4'd12);
    endfunction

    // Nonvolatile xmm register
    function automatic logic xmm_kept(input logic [3:0] r);
        xmm_kept = (r >= 4'd6);
    endfunction

endpackage

/* design/xuv_head_eval.sv */
// Combinational check of one unwind-code head slot against the walk state.
module xuv_head_eval (
    input  logic [7:0]         op_byte,
    input  logic [7:0]         head_offset,
    input  logic [7:0]         prologue_length,
    input  logic [8:0]         prev_offset,
    input  logic [7:0]         slot_total,
    input  logic [8:0]         slot,
    output xuv_pkg::head_res_t res
);
    import xuv_pkg::*;

    logic [3:0] op;
    logic [3:0] info;
    logic [3:0] op_err;
    logic [1:0] used;
    logic       fp_op;
    logic [7:0] remaining;

    assign op   = op_byte[3:0];
    assign info = op_byte[7:4];
    // slot is below slot_total whenever a head is evaluated
    assign remaining = slot_total - slot[7:0];

    // opcode legality, register class and slot usage
    always_comb begin
        op_err = ERR_OK;
        used   = 2'd1;
        fp_op  = 1'b0;
        unique case (op)
            UOP_PUSH_NONVOL: begin
                if (!gpr_kept(info)) op_err = ERR_PUSH_VOL;
            end
            UOP_ALLOC_LARGE: begin
                if (info > 4'd1) op_err = ERR_ALLOC;
                else used = (info == 4'd0) ? 2'd2 : 2'd3;
            end
            UOP_ALLOC_SMALL: begin
            end
            UOP_SET_FPREG: begin
                if (info != 4'd0) op_err = ERR_FPREG;
                else fp_op = 1'b1;
            end
            UOP_SAVE_NONVOL: begin
                if (!gpr_kept(info)) op_err = ERR_SAVE_VOL;
                else used = 2'd2;
            end
            UOP_SAVE_NONVOL_FAR: begin
                if (!gpr_kept(info)) op_err = ERR_SAVE_VOL;
                else used = 2'd3;
            end
            UOP_SAVE_XMM128: begin
                if (!xmm_kept(info)) op_err = ERR_XMM;
                else used = 2'd2;
            end
            UOP_SAVE_XMM128_FAR: begin
                if (!xmm_kept(info)) op_err = ERR_XMM;
                else used = 2'd3;
            end
            UOP_PUSH_MACHFRAME: begin
                if (info > 4'd1) op_err = ERR_MACHFRAME;
            end
            default: begin
                op_err = ERR_OPCODE;
            end
        endcase
    end

    // offset order first, then opcode checks, then slot room
    always_comb begin
        res.off_ok = (head_offset != 8'd0) && (head_offset <= prologue_length) &&
                     ({1'b0, head_offset} < prev_offset);
        res.fp_inc = 1'b0;
        res.next_slot = slot + {7'd0, used};
        if (!res.off_ok) begin
            res.err = ERR_ORDER;
        end else if (op_err != ERR_OK) begin
            res.err = op_err;
        end else if ({6'd0, used} > remaining) begin
            res.err = ERR_MULTISLOT;
        end else begin
            res.err = ERR_OK;
            res.fp_inc = fp_op;
        end
    end

endmodule

/* design/x64_unwind_info_validator.sv */
// Top level: streaming byte-wise validator for one x64 unwind descriptor.
// A byte is registered at input, then parsed; the verdict of the last byte is
// registered; a last byte waits while a verdict is held and not yet taken.
// Throughput: one byte per cycle from the single parse stage, bar that wait.
// Reset: synchronous active-low aresetn clears parser state and both valids;
// parser state also returns to its reset values after every verdict.
module x64_unwind_info_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_descriptor_ok,
    output logic [3:0] m_error_code
);
    import xuv_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       process_en;

    // parser state
    logic [9:0] byte_index_reg, byte_index_next, byte_index_upd;
    logic [7:0] prologue_length_reg, prologue_length_next, prologue_length_upd;
    logic [7:0] slot_total_reg, slot_total_next, slot_total_upd;
    logic [3:0] frame_reg_reg, frame_reg_next, frame_reg_upd;
    logic [3:0] frame_ofs_reg, frame_ofs_next, frame_ofs_upd;
    logic [8:0] next_head_reg, next_head_next, next_head_upd;
    logic [7:0] held_ofs_reg, held_ofs_next, held_ofs_upd;
    logic [8:0] last_ofs_reg, last_ofs_next, last_ofs_upd;
    logic [1:0] fp_count_reg, fp_count_next, fp_count_upd;
    logic [3:0] first_error_reg, first_error_next, first_error_upd;
    logic       padding_bad_reg, padding_bad_next, padding_bad_upd;
    logic       trailing_bad_reg, trailing_bad_next, trailing_bad_upd;

    // output register
    logic       m_valid_reg;
    logic       m_ok_reg;
    logic [3:0] m_code_reg;

    logic [8:0]  slots_even;
    logic [9:0]  desc_len;
    logic [9:0]  rel_idx;
    logic [8:0]  slot;
    logic        op_half;
    logic [10:0] size;
    logic [3:0]  verdict;
    head_res_t   head;

    // handshake: a non-last byte never waits on the result side
    assign process_en = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || process_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // descriptor geometry from the slot count
    assign slots_even = ({1'b0, slot_total_reg} + 9'd1) & ~9'd1;
    assign desc_len   = HDR_BYTES + {slots_even, 1'b0};
    assign rel_idx    = byte_index_reg - HDR_BYTES;
    assign slot       = rel_idx[9:1];
    assign op_half    = rel_idx[0];
    assign size       = {1'b0, byte_index_reg} + 11'd1;

    xuv_head_eval u_head (
        .op_byte          (in_data_reg),
        .head_offset      (held_ofs_reg),
        .prologue_length  (prologue_length_reg),
        .prev_offset      (last_ofs_reg),
        .slot_total       (slot_total_reg),
        .slot             (slot),
        .res              (head)
    );

    // byte parse: header, slot walk, padding, trailing
    always_comb begin
        byte_index_upd      = byte_index_reg;
        prologue_length_upd = prologue_length_reg;
        slot_total_upd      = slot_total_reg;
        frame_reg_upd       = frame_reg_reg;
        frame_ofs_upd       = frame_ofs_reg;
        next_head_upd       = next_head_reg;
        held_ofs_upd        = held_ofs_reg;
        last_ofs_upd        = last_ofs_reg;
        fp_count_upd        = fp_count_reg;
        first_error_upd     = first_error_reg;
        padding_bad_upd     = padding_bad_reg;
        trailing_bad_upd    = trailing_bad_reg;
        priority if (byte_index_reg == IDX_VERSION) begin
            if (in_data_reg != HDR_VERSION_FLAGS) first_error_upd = ERR_HEADER;
        end else if (byte_index_reg == IDX_PROLOGUE) begin
            prologue_length_upd = in_data_reg;
        end else if (byte_index_reg == IDX_SLOTS) begin
            slot_total_upd = in_data_reg;
        end else if (byte_index_reg == IDX_FRAME) begin
            frame_reg_upd = in_data_reg[3:0];
            frame_ofs_upd = in_data_reg[7:4];
        end else if (byte_index_reg >= desc_len) begin
            if (in_data_reg != 8'd0) trailing_bad_upd = 1'b1;
        end else if (slot < {1'b0, slot_total_reg}) begin
            if (first_error_reg == ERR_OK && slot == next_head_reg) begin
                if (!op_half) begin
                    held_ofs_upd = in_data_reg;
                end else begin
                    if (head.off_ok) last_ofs_upd = {1'b0, held_ofs_reg};
                    if (head.err != ERR_OK) begin
                        first_error_upd = head.err;
                    end else begin
                        next_head_upd = head.next_slot;
                        if (head.fp_inc && fp_count_reg < FP_SAT)
                            fp_count_upd = fp_count_reg + 2'd1;
                    end
                end
            end
        end else begin
            if (in_data_reg != 8'd0) padding_bad_upd = 1'b1;
        end
        if (byte_index_reg < IDX_SAT) byte_index_upd = byte_index_reg + 10'd1;
    end

    // verdict in check order, from the updated state
    always_comb begin
        verdict = ERR_OK;
        priority if (byte_index_reg < 10'd3 || first_error_upd == ERR_HEADER) begin
            verdict = ERR_HEADER;
        end else if (size < {1'b0, desc_len}) begin
            verdict = ERR_TRUNCATED;
        end else if (first_error_upd != ERR_OK) begin
            verdict = first_error_upd;
        end else if (padding_bad_upd) begin
            verdict = ERR_PAD;
        end else if (frame_reg_upd == 4'd0) begin
            if (frame_ofs_upd != 4'd0 || fp_count_upd != 2'd0) verdict = ERR_INCONSIST;
        end else begin
            if (!gpr_kept(frame_reg_upd) || fp_count_upd != 2'd1) verdict = ERR_BAD_FRAME;
        end
        if (verdict == ERR_OK && trailing_bad_upd) verdict = ERR_TRAILING;
    end

    // state advance, back to reset values after the verdict
    always_comb begin
        byte_index_next      = byte_index_reg;
        prologue_length_next = prologue_length_reg;
        slot_total_next      = slot_total_reg;
        frame_reg_next       = frame_reg_reg;
        frame_ofs_next       = frame_ofs_reg;
        next_head_next       = next_head_reg;
        held_ofs_next        = held_ofs_reg;
        last_ofs_next        = last_ofs_reg;
        fp_count_next        = fp_count_reg;
        first_error_next     = first_error_reg;
        padding_bad_next     = padding_bad_reg;
        trailing_bad_next    = trailing_bad_reg;
        if (process_en) begin
            if (in_last_reg) begin
                byte_index_next      = 10'd0;
                prologue_length_next = 8'd0;
                slot_total_next      = 8'd0;
                frame_reg_next       = 4'd0;
                frame_ofs_next       = 4'd0;
                next_head_next       = 9'd0;
                held_ofs_next        = 8'd0;
                last_ofs_next        = LAST_OFS_RESET;
                fp_count_next        = 2'd0;
                first_error_next     = ERR_OK;
                padding_bad_next     = 1'b0;
                trailing_bad_next    = 1'b0;
            end else begin
                byte_index_next      = byte_index_upd;
                prologue_length_next = prologue_length_upd;
                slot_total_next      = slot_total_upd;
                frame_reg_next       = frame_reg_upd;
                frame_ofs_next       = frame_ofs_upd;
                next_head_next       = next_head_upd;
                held_ofs_next        = held_ofs_upd;
                last_ofs_next        = last_ofs_upd;
                fp_count_next        = fp_count_upd;
                first_error_next     = first_error_upd;
                padding_bad_next     = padding_bad_upd;
                trailing_bad_next    = trailing_bad_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg      <= 10'd0;
            prologue_length_reg <= 8'd0;
            slot_total_reg      <= 8'd0;
            frame_reg_reg       <= 4'd0;
            frame_ofs_reg       <= 4'd0;
            next_head_reg       <= 9'd0;
            held_ofs_reg        <= 8'd0;
            last_ofs_reg        <= LAST_OFS_RESET;
            fp_count_reg        <= 2'd0;
            first_error_reg     <= ERR_OK;
            padding_bad_reg     <= 1'b0;
            trailing_bad_reg    <= 1'b0;
        end else begin
            byte_index_reg      <= byte_index_next;
            prologue_length_reg <= prologue_length_next;
            slot_total_reg      <= slot_total_next;
            frame_reg_reg       <= frame_reg_next;
            frame_ofs_reg       <= frame_ofs_next;
            next_head_reg       <= next_head_next;
            held_ofs_reg        <= held_ofs_next;
            last_ofs_reg        <= last_ofs_next;
            fp_count_reg        <= fp_count_next;
            first_error_reg     <= first_error_next;
            padding_bad_reg     <= padding_bad_next;
            trailing_bad_reg    <= trailing_bad_next;
        end
    end

    // result register: holds the verdict word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (process_en && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (process_en && in_last_reg) begin
            m_ok_reg   <= (verdict == ERR_OK);
            m_code_reg <= verdict;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_descriptor_ok = m_ok_reg;
    assign m_error_code    = m_code_reg;

`ifndef ASSERT_OFF
    a_ok_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_ok_reg == (m_code_reg == ERR_OK)))
        else $error("descriptor_ok disagrees with error_code");
    a_state_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (process_en && in_last_reg) |=> (byte_index_reg == 10'd0 &&
                                         first_error_reg == ERR_OK))
        else $error("parser state not cleared after verdict");
    a_index_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_index_reg <= IDX_SAT)
        else $error("byte index beyond saturation");
    a_fp_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        fp_count_reg <= FP_SAT)
        else $error("set-fpreg count beyond saturation");
    a_last_ofs_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        last_ofs_reg != 9'd0)
        else $error("last code offset became zero");
`endif

endmodule

/* bench/tb_x64_unwind_info_validator.sv */
`timescale 1ns / 1ps
// Self-checking bench for the unwind descriptor validator: byte stream in, one verdict out.
module tb_x64_unwind_info_validator;
    import xuv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_WORDS  = 120;   // last words of the run go without idling
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_word_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] code;
    } verdict_t;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte     = 8'h00;
    logic       s_last_byte     = 1'b0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic       m_descriptor_ok;
    logic [3:0] m_error_code;

    x64_unwind_info_validator i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_descriptor_ok(m_descriptor_ok),
        .m_error_code   (m_error_code)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stimulus and expected verdicts
    byte_word_t byte_stream_q[$];
    verdict_t   verdict_q[$];
    byte_word_t next_word;
    verdict_t   got_verdict;
    verdict_t   want_verdict;

    int  n_queued     = 0;
    int  n_desc       = 0;
    int  n_accepted   = 0;
    int  n_verdicts   = 0;
    int  n_fail       = 0;
    int  longest_desc = 0;
    int  cyc          = 0;
    int  src_gap      = 0;
    int  sink_gap     = 0;
    bit  long_done    = 0;
    bit  byte_taken   = 0;
    bit  idle_on      = 1;
    bit  code_hit[16];

    // Parser state of the predictor
    logic [9:0] at_byte;
    logic [7:0] prolog_len;
    logic [7:0] slot_cnt;
    logic [3:0] fr_reg;
    logic [3:0] fr_ofs;
    logic [8:0] head_slot;
    logic [7:0] pend_ofs;
    logic [8:0] prev_ofs;
    logic [1:0] fp_cnt;
    logic [3:0] err_seen;
    logic       pad_bad;
    logic       trail_bad;

    function automatic bit keeps_gpr(input logic [3:0] r);
        return r == 4'd3 || r == 4'd5 || r == 4'd6 || r == 4'd7 || r >= 4'd12;
    endfunction

    function automatic bit keeps_xmm(input logic [3:0] r);
        return r >= 4'd6;
    endfunction

    function automatic void clear_parser();
        at_byte    = '0;
        prolog_len = '0;
        slot_cnt   = '0;
        fr_reg     = '0;
        fr_ofs     = '0;
        head_slot  = '0;
        pend_ofs   = '0;
        prev_ofs   = LAST_OFS_RESET;
        fp_cnt     = '0;
        err_seen   = ERR_OK;
        pad_bad    = 1'b0;
        trail_bad  = 1'b0;
    endfunction

    // Check one head slot s against its operation byte
    function automatic void walk_head(input int s, input logic [7:0] opb);
        logic [3:0] op;
        logic [3:0] info;
        logic [3:0] err;
        int         used;
        op   = opb[3:0];
        info = opb[7:4];
        err  = ERR_OK;
        used = 1;
        if (pend_ofs == 8'd0 || pend_ofs > prolog_len || {1'b0, pend_ofs} >= prev_ofs) begin
            err_seen = ERR_ORDER;
            return;
        end
        prev_ofs = {1'b0, pend_ofs};
        case (op)
            UOP_PUSH_NONVOL: if (!keeps_gpr(info)) err = ERR_PUSH_VOL;
            UOP_ALLOC_LARGE: begin
                if (info > 4'd1) err = ERR_ALLOC;
                else used = (info == 4'd0) ? 2 : 3;
            end
            UOP_ALLOC_SMALL: ;
            UOP_SET_FPREG: begin
                if (info != 4'd0) err = ERR_FPREG;
                else if (fp_cnt < FP_SAT) fp_cnt = fp_cnt + 2'd1;
            end
            UOP_SAVE_NONVOL: begin
                if (!keeps_gpr(info)) err = ERR_SAVE_VOL;
                else used = 2;
            end
            UOP_SAVE_NONVOL_FAR: begin
                if (!keeps_gpr(info)) err = ERR_SAVE_VOL;
                else used = 3;
            end
            UOP_SAVE_XMM128: begin
                if (!keeps_xmm(info)) err = ERR_XMM;
                else used = 2;
            end
            UOP_SAVE_XMM128_FAR: begin
                if (!keeps_xmm(info)) err = ERR_XMM;
                else used = 3;
            end
            UOP_PUSH_MACHFRAME: if (info > 4'd1) err = ERR_MACHFRAME;
            default: err = ERR_OPCODE;
        endcase
        if (err == ERR_OK && used > int'(slot_cnt) - s) err = ERR_MULTISLOT;
        if (err != ERR_OK) begin
            err_seen = err;
            return;
        end
        head_slot = 9'(s + used);
    endfunction

    // Advance the parser by one byte; returns 1 with the verdict on the last byte
    function automatic bit predict_verdict(input logic [7:0] b, input logic lst,
                                           output verdict_t v);
        int         idx;
        int         desc;
        int         s;
        logic [3:0] code;
        v    = '0;
        idx  = int'(at_byte);
        desc = int'(HDR_BYTES) + 2 * ((int'(slot_cnt) + 1) & ~1);
        if (idx == int'(IDX_VERSION)) begin
            if (b != HDR_VERSION_FLAGS) err_seen = ERR_HEADER;
        end else if (idx == int'(IDX_PROLOGUE)) begin
            prolog_len = b;
        end else if (idx == int'(IDX_SLOTS)) begin
            slot_cnt = b;
        end else if (idx == int'(IDX_FRAME)) begin
            fr_reg = b[3:0];
            fr_ofs = b[7:4];
        end else if (idx >= desc) begin
            if (b != 8'd0) trail_bad = 1'b1;
        end else begin
            s = (idx - int'(HDR_BYTES)) >> 1;
            if (s < int'(slot_cnt)) begin
                if (err_seen == ERR_OK && s == int'(head_slot)) begin
                    if (((idx - int'(HDR_BYTES)) & 1) == 0) pend_ofs = b;
                    else walk_head(s, b);
                end
            end else if (b != 8'd0) begin
                pad_bad = 1'b1;
            end
        end
        if (at_byte < IDX_SAT) at_byte = at_byte + 10'd1;
        if (!lst) return 0;

        // Verdict in check order
        code = ERR_OK;
        if (idx + 1 < int'(HDR_BYTES) || err_seen == ERR_HEADER) code = ERR_HEADER;
        else if (idx + 1 < desc) code = ERR_TRUNCATED;
        else if (err_seen != ERR_OK) code = err_seen;
        else if (pad_bad) code = ERR_PAD;
        else if (fr_reg == 4'd0) begin
            if (fr_ofs != 4'd0 || fp_cnt != 2'd0) code = ERR_INCONSIST;
        end else if (!keeps_gpr(fr_reg) || fp_cnt != 2'd1) begin
            code = ERR_BAD_FRAME;
        end
        if (code == ERR_OK && trail_bad) code = ERR_TRAILING;
        v.ok   = (code == ERR_OK);
        v.code = code;
        clear_parser();
        return 1;
    endfunction

    // Stimulus builders
    task automatic queue_image(input logic [7:0] img[$]);
        byte_word_t w;
        for (int i = 0; i < img.size(); i++) begin
            w.data = img[i];
            w.last = (i == img.size() - 1);
            byte_stream_q = {byte_stream_q, w};
        end
        n_queued += img.size();
        n_desc++;
        if (img.size() > longest_desc) longest_desc = img.size();
    endtask

    // Bytes given most significant first
    task automatic queue_packed(input logic [63:0] bytes, input int len);
        logic [7:0] img[$];
        for (int i = len - 1; i >= 0; i--) img = {img, bytes[8*i +: 8]};
        queue_image(img);
    endtask

    function automatic logic [3:0] pick_kept_gpr();
        int k;
        k = $urandom_range(0, 7);
        case (k)
            0: return 4'd3;
            1: return 4'd5;
            2: return 4'd6;
            3: return 4'd7;
            default: return 4'(8 + k);
        endcase
    endfunction

    // Mostly well-formed descriptor with random content and the odd defect
    task automatic add_unwind_desc(input int n, input bit big);
        logic [7:0] img[$];
        logic [7:0] ob;
        logic [7:0] pb;
        logic [3:0] op;
        logic [3:0] info;
        int plen, ofs, s, used, heads, n_fp, bad_head, n_trail, cut;
        if (big) plen = 255;
        else if ($urandom_range(0, 3) == 0) plen = 2 * n + 1;
        else plen = $urandom_range(2 * n + 1, 255);
        img = {img, ($urandom_range(0, 15) == 0) ? 8'($urandom) : HDR_VERSION_FLAGS};
        img = {img, 8'(plen)};
        img = {img, 8'(n)};
        img = {img, 8'h00};
        bad_head = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : -1;
        ofs = plen + 1;
        s = 0;
        heads = 0;
        n_fp = 0;

        // Unwind codes with falling offsets
        while (s < n) begin
            ofs = ofs - (big ? 1 : $urandom_range(1, 2));
            info = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 8))
                0: begin op = UOP_PUSH_NONVOL; info = pick_kept_gpr(); used = 1; end
                1: begin op = UOP_ALLOC_LARGE; info = 4'($urandom_range(0, 1));
                         used = (info == 4'd0) ? 2 : 3; end
                2: begin op = UOP_ALLOC_SMALL; used = 1; end
                3: begin op = UOP_SET_FPREG; info = 4'd0; used = 1; end
                4: begin op = UOP_SAVE_NONVOL; info = pick_kept_gpr(); used = 2; end
                5: begin op = UOP_SAVE_NONVOL_FAR; info = pick_kept_gpr(); used = 3; end
                6: begin op = UOP_SAVE_XMM128; info = 4'($urandom_range(6, 15)); used = 2; end
                7: begin op = UOP_SAVE_XMM128_FAR; info = 4'($urandom_range(6, 15));
                         used = 3; end
                default: begin op = UOP_PUSH_MACHFRAME; info = 4'($urandom_range(0, 1));
                               used = 1; end
            endcase
            // keep frame setup rare after the first, and multi-slot ops inside the table
            if (used > n - s || (op == UOP_SET_FPREG && n_fp != 0
                                 && $urandom_range(0, 3) != 0)) begin
                op = UOP_ALLOC_SMALL;
                used = 1;
            end
            if (op == UOP_SET_FPREG) n_fp++;
            ob = 8'(ofs);
            pb = {info, op};
            if (heads == bad_head) begin
                case ($urandom_range(0, 3))
                    0: ob = 8'h00;
                    1: ob = 8'($urandom);
                    2: pb = 8'($urandom);
                    default: pb = {4'd1, UOP_ALLOC_LARGE};
                endcase
            end
            img = {img, ob};
            img = {img, pb};
            for (int k = 1; k < used; k++) begin
                img = {img, 8'($urandom)};
                img = {img, 8'($urandom)};
            end
            s += used;
            heads++;
        end

        // Padding slot
        if (n % 2 == 1) begin
            img = {img, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00};
            img = {img, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00};
        end

        // Frame register byte
        if ($urandom_range(0, 7) == 0) img[3] = 8'($urandom);
        else if (n_fp == 0) img[3] = 8'h00;
        else img[3] = {4'($urandom_range(0, 15)), pick_kept_gpr()};

        // Trailing bytes, past the counter limit for the big one
        n_trail = big ? $urandom_range(4, 12) : $urandom_range(0, 3);
        for (int k = 0; k < n_trail; k++) img = {img, 8'h00};
        if (n_trail != 0 && $urandom_range(0, 7) == 0)
            img[img.size() - 1 - $urandom_range(0, n_trail - 1)] = 8'($urandom_range(1, 255));

        // Occasional early end
        if (!big && img.size() > 1 && $urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, img.size() - 1);
            while (img.size() > cut) void'(img.pop_back());
        end
        queue_image(img);
    endtask

    // Source side: drive at the falling edge, hold until the word is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !byte_taken) begin
            // hold word
        end else if (src_gap > 0) begin
            s_valid <= 1'b0;
            src_gap <= src_gap - 1;
        end else if (byte_stream_q.size() > TAIL_WORDS && idle_on
                     && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            src_gap <= $urandom_range(0, 11);
        end else if (byte_stream_q.size() != 0) begin
            next_word   = byte_stream_q.pop_front();
            s_valid     <= 1'b1;
            s_data_byte <= next_word.data;
            s_last_byte <= next_word.last;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Sink side: stall in bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            m_ready  <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (byte_stream_q.size() > TAIL_WORDS && idle_on
                     && $urandom_range(0, 5) == 0) begin
            m_ready  <= 1'b0;
            sink_gap <= $urandom_range(0, 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Sample handshakes at the rising edge: predict on input, check on output
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts pending", cyc, verdict_q.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            if (cyc % 64 == 0) idle_on <= ($urandom_range(0, 3) != 0);
            byte_taken <= aresetn && s_valid && s_ready;

            if (aresetn && m_valid && m_ready) begin
                got_verdict.ok   = m_descriptor_ok;
                got_verdict.code = m_error_code;
                n_verdicts++;
                if (verdict_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected verdict ok=%0d code=%0d at cycle %0d",
                                 got_verdict.ok, got_verdict.code, cyc);
                end else begin
                    want_verdict = verdict_q.pop_front();
                    code_hit[want_verdict.code] = 1'b1;
                    if (got_verdict.ok !== want_verdict.ok
                        || got_verdict.code !== want_verdict.code) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("verdict %0d: expected ok=%0d code=%0d, got ok=%0d code=%0d",
                                     n_verdicts, want_verdict.ok, want_verdict.code,
                                     got_verdict.ok, got_verdict.code);
                    end
                end
            end

            if (aresetn && s_valid && s_ready) begin
                n_accepted++;
                if (predict_verdict(s_data_byte, s_last_byte, want_verdict))
                    verdict_q = {verdict_q, want_verdict};
            end
        end
    end

    initial begin
        int n_codes;
        clear_parser();
        foreach (code_hit[i]) code_hit[i] = 1'b0;

        // Directed: short streams, bad header, minimal ok, truncation, frame setup
        queue_packed(64'h00, 1);
        queue_packed(64'h01FF, 2);
        queue_packed(64'h01000000, 4);
        queue_packed(64'h010502000402, 6);
        queue_packed(64'hFFFFFFFF, 4);
        queue_packed(64'h0110013508030000, 8);

        // Random descriptors, plus one full table that runs the counter to its limit
        while (n_queued < 900 || n_desc < 60) begin
            if (!long_done && n_queued > 300) begin
                add_unwind_desc(255, 1);
                long_done = 1;
            end else if ($urandom_range(0, 9) == 0) begin
                logic [7:0] junk[$];
                int len;
                junk = {};
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++) junk = {junk, 8'($urandom)};
                if ($urandom_range(0, 1) == 0) junk[0] = HDR_VERSION_FLAGS;
                queue_image(junk);
            end else begin
                add_unwind_desc(($urandom_range(0, 3) == 0) ? $urandom_range(9, 40)
                                                           : $urandom_range(0, 8), 0);
            end
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_queued || verdict_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        n_codes = 0;
        foreach (code_hit[i]) n_codes += code_hit[i];
        $display("%0d descriptors in %0d bytes, longest %0d bytes; %0d verdicts checked",
                 n_desc, n_queued, longest_desc, n_verdicts);
        $display("%0d of 16 verdict codes seen, %0d mismatches", n_codes, n_fail);
        if (n_fail == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
